// ===== src/tcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcdf_pkg
// shared constants for the compare-timer tick block: register indexes,
// field widths and register reset values
// ----------------------------------------------------------------------------
package tcdf_pkg;

    // default counter width of the free-running timer
    localparam int COUNTER_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_JIFFY_STEP   = 3'd0,
        REG_ALARM_PERIOD = 3'd1,
        REG_CORR_ENABLE  = 3'd2,
        REG_CORR_PERIOD  = 3'd3,
        REG_CORR_AMOUNT  = 3'd4,
        REG_GUARD_MARGIN = 3'd5
    } cfg_idx_t;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int MILLIS_W = 32;
    localparam int STEP_W   = 8;
    localparam int PERIOD_W = 16;

    // register reset values
    localparam logic [STEP_W-1:0]   JIFFY_STEP_RST   = 8'd1;
    localparam logic [PERIOD_W-1:0] ALARM_PERIOD_RST = 16'd32;
    localparam logic                CORR_ENABLE_RST  = 1'b0;
    localparam logic [PERIOD_W-1:0] CORR_PERIOD_RST  = 16'd4096;
    localparam logic [STEP_W-1:0]   CORR_AMOUNT_RST  = 8'd3;
    localparam logic [STEP_W-1:0]   GUARD_MARGIN_RST = 8'd2;

endpackage

// ===== src/tick_catchup_with_drift_fix.sv =====
// ----------------------------------------------------------------------------
// tick_catchup_with_drift_fix
// millisecond tick from a compare timer interrupt, with alarm catch-up,
// optional drift correction and a final guard against a compare in the past
// ----------------------------------------------------------------------------
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  s_      | s_valid s_ready s_count_at_entry s_count_later     | in
//          | s_sleeping                                        |
//  m_      | m_valid m_ready m_millis_count m_next_compare      | out
//          | m_wake_request                                    |
//  cfg_    | cfg_wr_en cfg_wr_idx cfg_wr_data                   | in
//
//  one compare advance per cycle through a single shared add/compare unit
//  an awake transfer runs the catch-up loop, the correction loop when correction
//  is on, and the guard loop, then hands its result over in ST_DONE
//  (each loop stops after 2^COUNTER_BITS advances); a sleep transfer goes
//  straight from idle to ST_DONE
//  s_ready is high only while the sequencer is idle; a finished result waits
//  in the output register, so the next transfer can be taken meanwhile
//  aresetn is synchronous, active low, and restores config and sequencer state
//
module tick_catchup_with_drift_fix #(
    parameter int COUNTER_BITS = tcdf_pkg::COUNTER_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [tcdf_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  logic [tcdf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,

    // interrupt items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tcdf_pkg::SAMPLE_W-1:0]    s_count_at_entry,
    input  logic [tcdf_pkg::SAMPLE_W-1:0]    s_count_later,
    input  logic                             s_sleeping,

    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcdf_pkg::MILLIS_W-1:0]    m_millis_count,
    output logic [tcdf_pkg::SAMPLE_W-1:0]    m_next_compare,
    output logic                             m_wake_request
);

    import tcdf_pkg::*;

    localparam int CB = COUNTER_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CATCH,   // alarm catch-up against the entry sample
        ST_FIX,     // drift correction compare against the entry sample
        ST_GUARD,   // alarm catch-up against later sample plus margin
        ST_DONE     // hand the result to the output register
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]   jiffy_step_reg;
    logic [PERIOD_W-1:0] alarm_period_reg;
    logic                corr_enable_reg;
    logic [PERIOD_W-1:0] corr_period_reg;
    logic [STEP_W-1:0]   corr_amount_reg;
    logic [STEP_W-1:0]   guard_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jiffy_step_reg   <= JIFFY_STEP_RST;
            alarm_period_reg <= ALARM_PERIOD_RST;
            corr_enable_reg  <= CORR_ENABLE_RST;
            corr_period_reg  <= CORR_PERIOD_RST;
            corr_amount_reg  <= CORR_AMOUNT_RST;
            guard_margin_reg <= GUARD_MARGIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                REG_JIFFY_STEP:   jiffy_step_reg   <= cfg_wr_data[STEP_W-1:0];
                REG_ALARM_PERIOD: alarm_period_reg <= cfg_wr_data[PERIOD_W-1:0];
                REG_CORR_ENABLE:  corr_enable_reg  <= cfg_wr_data[0];
                REG_CORR_PERIOD:  corr_period_reg  <= cfg_wr_data[PERIOD_W-1:0];
                REG_CORR_AMOUNT:  corr_amount_reg  <= cfg_wr_data[STEP_W-1:0];
                REG_GUARD_MARGIN: guard_margin_reg <= cfg_wr_data[STEP_W-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // timer state and sequencer registers
    // ------------------------------------------------------------------
    state_t                state_reg,     state_next;
    logic [MILLIS_W-1:0]   millis_reg,    millis_next;
    logic [CB-1:0]         alarm_reg,     alarm_next;
    logic [CB-1:0]         fix_reg,       fix_next;
    logic [CB-1:0]         entry_reg,     entry_next;
    logic [CB-1:0]         guard_reg,     guard_next;
    logic [CB:0]           iter_reg,      iter_next;
    logic                  wake_reg,      wake_next;

    logic                  m_valid_reg,   m_valid_next;
    logic [MILLIS_W-1:0]   m_millis_reg,  m_millis_next;
    logic [SAMPLE_W-1:0]   m_cmp_reg,     m_cmp_next;
    logic                  m_wake_reg,    m_wake_next;

    // samples folded into the counter width
    logic [31:0]   entry_w32;
    logic [31:0]   later_w32;
    logic [CB-1:0] entry_c;
    logic [CB-1:0] later_c;
    logic [31:0]   alarm_w32;

    assign entry_w32 = 32'(s_count_at_entry);
    assign later_w32 = 32'(s_count_later);
    assign entry_c   = entry_w32[CB-1:0];
    assign later_c   = later_w32[CB-1:0];
    assign alarm_w32 = 32'(alarm_reg);

    // ------------------------------------------------------------------
    // shared advance unit: one compare test and one advance per cycle
    // ------------------------------------------------------------------
    logic                in_fix;
    logic [CB-1:0]       cmp_sel;
    logic [CB-1:0]       lim_sel;
    logic [CB-1:0]       period_sel;
    logic [CB-1:0]       diff;
    logic [CB-1:0]       cmp_sum;
    logic [MILLIS_W-1:0] millis_delta;
    logic [MILLIS_W-1:0] millis_sum;
    logic                not_after;
    logic                cap_hit;
    logic                advance;
    logic                in_xfer;
    logic                out_load;

    assign in_fix     = (state_reg == ST_FIX);
    assign cmp_sel    = in_fix ? fix_reg : alarm_reg;
    assign lim_sel    = (state_reg == ST_GUARD) ? guard_reg : entry_reg;
    assign period_sel = in_fix ? CB'(32'(corr_period_reg)) : CB'(32'(alarm_period_reg));

    // compare is not after limit when (limit - compare) reads non-negative
    assign diff      = lim_sel - cmp_sel;
    assign not_after = ~diff[CB-1];
    // one full orbit of the compare ends the loop
    assign cap_hit   = iter_reg[CB];
    assign advance   = not_after & ~cap_hit;

    assign cmp_sum      = cmp_sel + period_sel;
    assign millis_delta = in_fix ? (~MILLIS_W'(corr_amount_reg) + MILLIS_W'(1))
                                 : MILLIS_W'(jiffy_step_reg);
    assign millis_sum   = millis_reg + millis_delta;

    assign in_xfer  = s_valid & s_ready;
    assign out_load = (state_reg == ST_DONE) & (~m_valid_reg | m_ready);

    always_comb begin
        state_next    = state_reg;
        millis_next   = millis_reg;
        alarm_next    = alarm_reg;
        fix_next      = fix_reg;
        entry_next    = entry_reg;
        guard_next    = guard_reg;
        iter_next     = iter_reg;
        wake_next     = wake_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_millis_next = m_millis_reg;
        m_cmp_next    = m_cmp_reg;
        m_wake_next   = m_wake_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    entry_next = entry_c;
                    guard_next = later_c + CB'(32'(guard_margin_reg));
                    iter_next  = '0;
                    wake_next  = s_sleeping;
                    // sleep only asks for wake-up, state stays as is
                    state_next = s_sleeping ? ST_DONE : ST_CATCH;
                end
            end
            ST_CATCH, ST_GUARD: begin
                if (advance) begin
                    alarm_next  = cmp_sum;
                    millis_next = millis_sum;
                    iter_next   = iter_reg + (CB+1)'(1);
                end else begin
                    iter_next = '0;
                    if (state_reg == ST_GUARD) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = corr_enable_reg ? ST_FIX : ST_GUARD;
                    end
                end
            end
            ST_FIX: begin
                if (advance) begin
                    fix_next    = cmp_sum;
                    millis_next = millis_sum;
                    iter_next   = iter_reg + (CB+1)'(1);
                end else begin
                    iter_next  = '0;
                    state_next = ST_GUARD;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    m_millis_next = millis_reg;
                    m_cmp_next    = alarm_w32[SAMPLE_W-1:0];
                    m_wake_next   = wake_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            millis_reg  <= '0;
            alarm_reg   <= CB'(32'(ALARM_PERIOD_RST));
            fix_reg     <= CB'(32'(CORR_PERIOD_RST));
            iter_reg    <= '0;
            wake_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            millis_reg  <= millis_next;
            alarm_reg   <= alarm_next;
            fix_reg     <= fix_next;
            iter_reg    <= iter_next;
            wake_reg    <= wake_next;
            m_valid_reg <= m_valid_next;
        end
        // payload, no reset needed
        entry_reg    <= entry_next;
        guard_reg    <= guard_next;
        m_millis_reg <= m_millis_next;
        m_cmp_reg    <= m_cmp_next;
        m_wake_reg   <= m_wake_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_millis_count = m_millis_reg;
    assign m_next_compare = m_cmp_reg;
    assign m_wake_request = m_wake_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a sleep transfer leaves count and compares untouched
    a_sleep_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_sleeping |=> $stable(millis_reg) && $stable(alarm_reg)
                                  && $stable(fix_reg))
        else $error("sleep transfer changed timer state");

    // loop counter never runs past one full orbit
    a_iter_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg[CB] |-> (iter_reg[CB-1:0] == '0) && !advance)
        else $error("catch-up loop ran past its cap");

    // a loaded result matches the settled count
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && (m_millis_count == millis_reg)
                     && (m_next_compare == alarm_w32[SAMPLE_W-1:0]))
        else $error("result does not match timer state");

    // the sequencer only leaves idle on an input transfer
    a_start_on_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && !in_xfer |=> (state_reg == ST_IDLE))
        else $error("sequencer started without a transfer");

endmodule

// ===== test/tb_tick_catchup_with_drift_fix.sv =====
// ----------------------------------------------------------------------------
// tb_tick_catchup_with_drift_fix
// Self-checking bench for the compare-timer tick block. A queue of interrupt
// transfers is planned phase by phase, each phase under its own register
// setting. A built-in predictor works out the millisecond count and the next
// alarm compare for every accepted transfer. A monitor checks every result
// transfer field by field. Both channels idle at random, and the result side
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_tick_catchup_with_drift_fix;
    timeunit 1ns;
    timeprecision 1ps;

    import tcdf_pkg::*;

    // one full orbit of the compare value bounds every catch-up loop
    localparam int unsigned ORBIT = 1 << COUNTER_BITS_DEF;
    // long result-side hold-off, placed partway into the random part
    localparam int PRESSURE_AT  = 400;
    localparam int PRESSURE_LEN = 300;
    // random part: phases of interrupt transfers, each with fresh registers
    localparam int RAND_PHASES    = 10;
    localparam int IRQS_PER_PHASE = 100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] entry;
        logic [SAMPLE_W-1:0] later;
        logic                sleeping;
    } irq_t;

    typedef struct packed {
        logic [MILLIS_W-1:0] millis;
        logic [SAMPLE_W-1:0] compare;
        logic                wake;
    } tick_t;

    // timekeeping state of the block
    typedef struct {
        logic [MILLIS_W-1:0] millis;
        logic [SAMPLE_W-1:0] alarm;
        logic [SAMPLE_W-1:0] fix;
    } clock_state_t;

    // register mirror
    typedef struct {
        logic [STEP_W-1:0]   step;
        logic [PERIOD_W-1:0] alarm_period;
        logic                corr_en;
        logic [PERIOD_W-1:0] corr_period;
        logic [STEP_W-1:0]   corr_amount;
        logic [STEP_W-1:0]   margin;
    } regs_t;

    logic                  aclk;
    logic                  aresetn          = 1'b0;
    logic                  cfg_wr_en        = 1'b0;
    cfg_idx_t              cfg_wr_idx       = REG_JIFFY_STEP;
    logic [CFG_DATA_W-1:0] cfg_wr_data      = '0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_count_at_entry = '0;
    logic [SAMPLE_W-1:0]   s_count_later    = '0;
    logic                  s_sleeping       = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [MILLIS_W-1:0]   m_millis_count;
    logic [SAMPLE_W-1:0]   m_next_compare;
    logic                  m_wake_request;

    regs_t        regs;
    clock_state_t plan_state;    // runs ahead while transfers are planned
    clock_state_t model_state;   // advanced as transfers are accepted

    irq_t  irq_backlog[$];       // planned interrupts not yet offered
    tick_t tick_outcomes[$];     // predicted results, oldest first

    int    irqs_planned  = 0;
    int    irqs_sent     = 0;
    int    outcomes_seen = 0;
    int    tick_errors   = 0;
    longint cycle_count  = 0;
    longint cycle_budget = 20000;  // reset, drains and the long hold-off

    int          tx_hold = 0;
    int          rx_hold = 0;
    int          rx_next;
    irq_t        irq_cur;
    tick_t       isr_res;
    tick_t       want;
    int unsigned isr_moves;

    tick_catchup_with_drift_fix uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_idx       (cfg_wr_idx),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_count_at_entry (s_count_at_entry),
        .s_count_later    (s_count_later),
        .s_sleeping       (s_sleeping),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_millis_count   (m_millis_count),
        .m_next_compare   (m_next_compare),
        .m_wake_request   (m_wake_request)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // compare value cmp is due once t has reached it in wrapping order
    function automatic bit is_due(input logic [SAMPLE_W-1:0] cmp,
                                  input logic [SAMPLE_W-1:0] t);
        logic [SAMPLE_W-1:0] gap;
        gap = t - cmp;
        return !gap[SAMPLE_W-1];
    endfunction

    // one compare interrupt: catch-up, drift correction, final guard;
    // moves counts every compare advance, which is what costs cycles
    task automatic run_tick_isr(inout clock_state_t st, input regs_t r, input irq_t irq,
                                output tick_t res, output int unsigned moves);
        int unsigned n;
        logic [SAMPLE_W-1:0] limit;
        moves = 0;
        if (!irq.sleeping) begin
            // catch the alarm up to the entry sample
            n = 0;
            while (n < ORBIT && is_due(st.alarm, irq.entry)) begin
                st.millis += r.step;
                st.alarm  += r.alarm_period;
                n++;
            end
            moves += n;
            // drift correction takes milliseconds back off the count
            if (r.corr_en) begin
                n = 0;
                while (n < ORBIT && is_due(st.fix, irq.entry)) begin
                    st.fix    += r.corr_period;
                    st.millis -= r.corr_amount;
                    n++;
                end
                moves += n;
            end
            // the compare must land beyond the later sample plus the margin
            limit = irq.later + SAMPLE_W'(r.margin);
            n = 0;
            while (n < ORBIT && is_due(st.alarm, limit)) begin
                st.millis += r.step;
                st.alarm  += r.alarm_period;
                n++;
            end
            moves += n;
        end
        // a sleeping interrupt only asks for wake-up and leaves state alone
        res.millis  = st.millis;
        res.compare = st.alarm;
        res.wake    = irq.sleeping;
    endtask

    // register write while the block is idle; the mirror follows at once
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_JIFFY_STEP:   regs.step         = val[STEP_W-1:0];
            REG_ALARM_PERIOD: regs.alarm_period = val;
            REG_CORR_ENABLE:  regs.corr_en      = val[0];
            REG_CORR_PERIOD:  regs.corr_period  = val;
            REG_CORR_AMOUNT:  regs.corr_amount  = val[STEP_W-1:0];
            REG_GUARD_MARGIN: regs.margin       = val[STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cycle_budget += 8;
    endtask

    // plan one interrupt: run it through the look-ahead state to size the
    // time limit, then hand it to the driver
    task automatic queue_irq(input logic [SAMPLE_W-1:0] entry,
                             input logic [SAMPLE_W-1:0] later, input logic sleeping);
        irq_t irq;
        tick_t res;
        int unsigned moves;
        irq.entry    = entry;
        irq.later    = later;
        irq.sleeping = sleeping;
        run_tick_isr(plan_state, regs, irq, res, moves);
        // block cycles plus worst gaps and stalls, with plenty of slack
        cycle_budget += 4 * (longint'(moves) + 40);
        irq_backlog.push_back(irq);
        irqs_planned++;
    endtask

    // wait for every planned result, then let the sequencer settle
    task automatic wait_idle();
        while (outcomes_seen < irqs_planned) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cycle_budget += 200;
    endtask

    // stimulus: directed phases first, then random phases
    initial begin
        int pick;
        int span;
        int lspan;
        int per;
        int cper_lo;
        logic [SAMPLE_W-1:0] entry;
        logic [SAMPLE_W-1:0] later;

        regs.step         = JIFFY_STEP_RST;
        regs.alarm_period = ALARM_PERIOD_RST;
        regs.corr_en      = CORR_ENABLE_RST;
        regs.corr_period  = CORR_PERIOD_RST;
        regs.corr_amount  = CORR_AMOUNT_RST;
        regs.margin       = GUARD_MARGIN_RST;
        plan_state.millis = '0;
        plan_state.alarm  = ALARM_PERIOD_RST;
        plan_state.fix    = CORR_PERIOD_RST;
        model_state       = plan_state;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset registers: sleep with counter extremes, no-advance and
        // small catch-up interrupts
        queue_irq(16'hFFFF, 16'hFFFF, 1'b1);
        queue_irq(16'h0000, 16'h0000, 1'b0);
        queue_irq(16'hFFFF, 16'hFFFF, 1'b0);
        queue_irq(16'd100, 16'd100, 1'b0);
        queue_irq(16'h0000, 16'hFFFF, 1'b1);
        wait_idle();

        // heavy correction drags the count below zero so it wraps
        write_reg(REG_ALARM_PERIOD, 16'd16384);
        write_reg(REG_CORR_ENABLE, 16'd1);
        write_reg(REG_CORR_PERIOD, 16'd1);
        write_reg(REG_CORR_AMOUNT, 16'd255);
        write_reg(REG_GUARD_MARGIN, 16'd0);
        queue_irq(plan_state.fix + 16'd200, plan_state.fix + 16'd200, 1'b0);
        queue_irq(16'h5555, 16'hAAAA, 1'b1);
        wait_idle();

        // largest step with period one and widest margin: count wraps back up
        write_reg(REG_JIFFY_STEP, 16'd255);
        write_reg(REG_ALARM_PERIOD, 16'd1);
        write_reg(REG_CORR_ENABLE, 16'd0);
        write_reg(REG_GUARD_MARGIN, 16'd255);
        queue_irq(plan_state.alarm + 16'd5, plan_state.alarm + 16'd5, 1'b0);
        // later sample far behind: the guard has nothing to do
        queue_irq(plan_state.alarm - 16'd1, plan_state.alarm - 16'd300, 1'b0);
        wait_idle();

        // largest period walks the compare backward: one long catch-up
        write_reg(REG_JIFFY_STEP, 16'd1);
        write_reg(REG_ALARM_PERIOD, 16'hFFFF);
        write_reg(REG_GUARD_MARGIN, 16'd0);
        queue_irq(plan_state.alarm - 16'd1, plan_state.alarm - 16'd2, 1'b0);
        queue_irq(plan_state.alarm, plan_state.alarm, 1'b0);
        wait_idle();

        // period of half the counter range
        write_reg(REG_JIFFY_STEP, 16'd200);
        write_reg(REG_ALARM_PERIOD, 16'h8000);
        queue_irq(plan_state.alarm, plan_state.alarm + 16'd10, 1'b0);
        queue_irq(plan_state.alarm + 16'h7FFF, plan_state.alarm, 1'b0);
        wait_idle();

        // largest correction period with nothing subtracted
        write_reg(REG_ALARM_PERIOD, 16'd1000);
        write_reg(REG_CORR_ENABLE, 16'd1);
        write_reg(REG_CORR_PERIOD, 16'hFFFF);
        write_reg(REG_CORR_AMOUNT, 16'd0);
        write_reg(REG_GUARD_MARGIN, 16'd3);
        queue_irq(plan_state.fix, plan_state.fix, 1'b0);
        queue_irq(plan_state.alarm, plan_state.alarm + 16'd40, 1'b1);
        wait_idle();

        // random phases; entries land near the current alarm compare so the
        // loops stay short, with early and late interrupts mixed in
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(0, 3);
            write_reg(REG_JIFFY_STEP, (pick == 0) ? 16'd1 :
                                      (pick == 1) ? 16'd255 : 16'($urandom_range(1, 255)));
            case ($urandom_range(0, 3))
                0: per = 1;
                1: per = $urandom_range(1, 64);
                2: per = $urandom_range(65, 2000);
                default: per = $urandom_range(2001, 60000);
            endcase
            write_reg(REG_ALARM_PERIOD, 16'(per));
            write_reg(REG_CORR_ENABLE, 16'($urandom_range(0, 1)));
            // correction period kept away from tiny values so catch-up is short
            cper_lo = (per / 4 > 256) ? per / 4 : 256;
            write_reg(REG_CORR_PERIOD, 16'($urandom_range(cper_lo, 60000)));
            pick = $urandom_range(0, 3);
            write_reg(REG_CORR_AMOUNT, (pick == 0) ? 16'd0 :
                                       (pick == 1) ? 16'd255 : 16'($urandom_range(0, 255)));
            pick = $urandom_range(0, 3);
            write_reg(REG_GUARD_MARGIN, (pick == 0) ? 16'd0 :
                                        (pick == 1) ? 16'd255 : 16'($urandom_range(0, 255)));

            span  = (4 * per < 30000) ? 4 * per : 30000;
            lspan = (8 * per < 30000) ? 8 * per : 30000;
            for (int i = 0; i < IRQS_PER_PHASE; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    queue_irq(16'($urandom), 16'($urandom), 1'b1);
                end else begin
                    if (pick < 18) begin
                        // interrupt before the compare is due
                        entry = plan_state.alarm - 16'($urandom_range(1, 300));
                    end else begin
                        entry = plan_state.alarm + 16'($urandom_range(0, span));
                    end
                    pick = $urandom_range(0, 19);
                    if (pick == 0) begin
                        later = entry - 16'($urandom_range(0, 2000));
                    end else if (pick == 1) begin
                        later = entry + 16'($urandom_range(0, lspan));
                    end else begin
                        later = entry + 16'($urandom_range(0, 64));
                    end
                    queue_irq(entry, later, 1'b0);
                end
            end
            wait_idle();
        end

        repeat (16) @(posedge aclk);
        if (tick_outcomes.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, tick_outcomes.size());
            tick_errors++;
        end
        if (tick_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // interrupt driver: offers backlog entries, predicts on each transfer,
    // then idles for the drawn gap; every other stretch of 64 has no gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_hold <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                run_tick_isr(model_state, regs, irq_cur, isr_res, isr_moves);
                tick_outcomes.push_back(isr_res);
            end
            if (tx_hold != 0) begin
                tx_hold <= tx_hold - 1;
                s_valid <= 1'b0;
            end else if (irq_backlog.size() != 0) begin
                irq_cur = irq_backlog.pop_front();
                s_count_at_entry <= irq_cur.entry;
                s_count_later    <= irq_cur.later;
                s_sleeping       <= irq_cur.sleeping;
                s_valid          <= 1'b1;
                irqs_sent++;
                tx_hold <= irqs_sent[6] ? 0 : $urandom_range(0, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor: compares each transfer with the oldest prediction and
    // stalls the result side for a drawn number of cycles afterwards
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tick_outcomes.size() == 0) begin
                    $display("%0t: result with none predicted: millis %h compare %h wake %b",
                             $time, m_millis_count, m_next_compare, m_wake_request);
                    tick_errors++;
                end else begin
                    want = tick_outcomes.pop_front();
                    if (m_millis_count !== want.millis) begin
                        $display("%0t: millis_count expected %h got %h",
                                 $time, want.millis, m_millis_count);
                        tick_errors++;
                    end
                    if (m_next_compare !== want.compare) begin
                        $display("%0t: next_compare expected %h got %h",
                                 $time, want.compare, m_next_compare);
                        tick_errors++;
                    end
                    if (m_wake_request !== want.wake) begin
                        $display("%0t: wake_request expected %b got %b",
                                 $time, want.wake, m_wake_request);
                        tick_errors++;
                    end
                end
                outcomes_seen++;
                // one long hold-off lets the block fill and stall its input
                if (outcomes_seen == PRESSURE_AT) begin
                    rx_next = PRESSURE_LEN;
                end else begin
                    rx_next = outcomes_seen[5] ? 0 : $urandom_range(0, 8);
                end
            end else if (rx_hold != 0) begin
                rx_next = rx_hold - 1;
            end else begin
                rx_next = 0;
            end
            rx_hold <= rx_next;
            m_ready <= (rx_next == 0);
        end
    end

    // time limit grows with every planned interrupt
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ===== tick_catchup_with_drift_fix.f =====
src/tcdf_pkg.sv
src/tick_catchup_with_drift_fix.sv
test/tb_tick_catchup_with_drift_fix.sv
